// File: rtl/core/rat_pkg.sv
// shared types, codes and reset constants of the relay allocation table
package rat_pkg;

  localparam int RAT_MAX_ALLOCS   = 64;
  localparam int RAT_MAX_PERMS    = 8;
  localparam int RAT_MAX_CHANNELS = 8;

  localparam logic [15:0] RST_DEFAULT_LIFE = 16'd600;
  localparam logic [15:0] RST_MAX_LIFE     = 16'd3600;
  localparam logic [15:0] RST_CHAN_LOW     = 16'd16384;
  localparam logic [15:0] RST_CHAN_HIGH    = 16'd32767;
  localparam logic [15:0] RST_PORT_BASE    = 16'd49152;
  localparam logic [15:0] RST_PERM_LIFE    = 16'd300;
  localparam logic [15:0] RST_CHAN_LIFE    = 16'd600;
  localparam logic [31:0] RST_NEXT_IDENT   = 32'd1;

  typedef enum logic [3:0] {
    MODE_ALLOC   = 4'd0,
    MODE_REFRESH = 4'd1,
    MODE_DEALLOC = 4'd2,
    MODE_FIND    = 4'd3,
    MODE_PERMIT  = 4'd4,
    MODE_CHECK   = 4'd5,
    MODE_BIND    = 4'd6,
    MODE_FINDCH  = 4'd7,
    MODE_EXPIRE  = 4'd8,
    MODE_COUNT   = 4'd9
  } mode_t;

  typedef enum logic [2:0] {
    STAT_OK       = 3'd0,
    STAT_NOTFOUND = 3'd1,
    STAT_FULL     = 3'd2,
    STAT_CONFLICT = 3'd3,
    STAT_RANGE    = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    CFG_RELAY_ADDR   = 3'd0,
    CFG_DEFAULT_LIFE = 3'd1,
    CFG_MAX_LIFE     = 3'd2,
    CFG_CHAN_LOW     = 3'd3,
    CFG_CHAN_HIGH    = 3'd4,
    CFG_PORT_BASE    = 3'd5,
    CFG_PERM_LIFE    = 3'd6,
    CFG_CHAN_LIFE    = 3'd7
  } cfg_idx_t;

  // what a scan pass compares and does on a hit
  typedef enum logic [3:0] {
    K_FREE, K_ID, K_CLIENT, K_AEXP,
    K_PERM, K_PERML, K_CHAN, K_CHANL,
    K_PEXP, K_CEXP, K_CLRP, K_CLRC
  } scan_kind_t;

  typedef enum logic [3:0] {
    S_IDLE, S_RANGE, S_ASCAN, S_RSTART, S_RSCAN,
    S_CLRP0, S_CLRP, S_CLRC, S_SWA, S_SWP, S_SWC, S_REPLY
  } state_t;

  typedef struct packed {
    logic       load;
    logic       start;
    scan_kind_t kind;
    logic       run;
    logic       alloc;
    logic       sel;
    logic       drop;
    logic       refresh;
    logic       perm_wr;
    logic       chan_wr;
    logic       peer;
    logic       set_st;
    status_t    st;
  } cmd_t;

  typedef struct packed {
    logic done;
    logic hit;
    logic free;
    logic conflict;
    logic range_bad;
    logic life_zero;
  } sts_t;

  typedef struct packed {
    logic [31:0] ident;
    logic [31:0] caddr;
    logic [15:0] cport;
    logic [15:0] rport;
  } ainfo_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] peer;
    logic [32:0] expiry;
  } perm_ent_t;

  typedef struct packed {
    logic        valid;
    logic [15:0] number;
    logic [31:0] paddr;
    logic [15:0] pport;
    logic [32:0] expiry;
  } chan_ent_t;

endpackage

// File: rtl/core/relay_allocation_table.sv
// sequence: each request scans the A allocation slots; permit, check, bind and find-channel
//   add a row scan, bind after a range check; allocate clears the new rows; expire sweeps every row
// throughput: one request at a time, set by the single-port table scans; busy stays high until
//   the result beat, which is one cycle wide and cannot be stalled
// reset: synchronous active-low rst_n empties the table, loads register defaults, id 1, port 49152
// permission and channel rows are cleared by passes when their allocation is created, not at reset
module relay_allocation_table import rat_pkg::*; #(
  parameter int MAX_ALLOCS   = RAT_MAX_ALLOCS,
  parameter int MAX_PERMS    = RAT_MAX_PERMS,
  parameter int MAX_CHANNELS = RAT_MAX_CHANNELS
) (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        start,
  output logic        busy,
  input  logic [3:0]  in_mode,
  input  logic [31:0] in_now_seconds,
  input  logic [31:0] in_client_address,
  input  logic [15:0] in_client_port_in,
  input  logic [31:0] in_allocation_id,
  input  logic [15:0] in_lifetime_seconds,
  input  logic [31:0] in_peer_address,
  input  logic [15:0] in_peer_port_in,
  input  logic [15:0] in_channel_number,
  // result channel
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic [31:0] out_found_id,
  output logic [15:0] out_found_relay_port,
  output logic [31:0] out_found_peer_address,
  output logic [15:0] out_found_peer_port,
  output logic [10:0] out_expired_count,
  output logic [6:0]  out_allocation_count,
  // register write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  cmd_t cmd;
  sts_t sts;

  // the user must write registers only between requests, not enforced; writes are always taken
  assign cfg_ready = 1'b1;

  // sequencer: walks each request through its scan passes
  rat_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_mode (in_mode),
    .sts     (sts),
    .cmd     (cmd),
    .busy    (busy),
    .reply   (out_valid)
  );

  // tables, scan engine and result registers
  rat_datapath #(
    .MAX_ALLOCS   (MAX_ALLOCS),
    .MAX_PERMS    (MAX_PERMS),
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr              (cfg_valid & cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_now_seconds      (in_now_seconds),
    .in_client_address   (in_client_address),
    .in_client_port_in   (in_client_port_in),
    .in_allocation_id    (in_allocation_id),
    .in_lifetime_seconds (in_lifetime_seconds),
    .in_peer_address     (in_peer_address),
    .in_peer_port_in     (in_peer_port_in),
    .in_channel_number   (in_channel_number),
    .cmd                 (cmd),
    .sts                 (sts),
    .res_status          (out_status),
    .res_id              (out_found_id),
    .res_port            (out_found_relay_port),
    .res_paddr           (out_found_peer_address),
    .res_pport           (out_found_peer_port),
    .res_expired         (out_expired_count),
    .res_count           (out_allocation_count)
  );

`ifndef NO_ASSERTIONS
  // a result beat returns the block to idle
  a_reply_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !busy) else $error("busy after result beat");

  // an accepted request always occupies the block
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("request accepted without going busy");

  // live count never exceeds the table size
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_allocation_count <= 7'(MAX_ALLOCS)) else $error("allocation count overflow");

  // reported status is a defined code
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == STAT_OK || out_status == STAT_NOTFOUND ||
                   out_status == STAT_FULL || out_status == STAT_CONFLICT ||
                   out_status == STAT_RANGE)) else $error("undefined status code");
`endif

endmodule

// File: rtl/core/rat_ctrl.sv
// request sequencer of the relay allocation table
module rat_ctrl import rat_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [3:0] in_mode,
  input  sts_t       sts,
  output cmd_t       cmd,
  output logic       busy,
  output logic       reply
);

  state_t state_r, state_nxt;
  mode_t  mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      mode_r  <= MODE_COUNT;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_IDLE && start) mode_r <= mode_t'(in_mode);
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.kind  = K_FREE;
    cmd.st    = STAT_OK;
    busy      = (state_r != S_IDLE);
    reply     = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          case (mode_t'(in_mode))
            MODE_ALLOC: begin
              cmd.start = 1'b1; cmd.kind = K_FREE; state_nxt = S_ASCAN;
            end
            MODE_REFRESH, MODE_DEALLOC, MODE_PERMIT, MODE_CHECK, MODE_FINDCH: begin
              cmd.start = 1'b1; cmd.kind = K_ID; state_nxt = S_ASCAN;
            end
            MODE_FIND: begin
              cmd.start = 1'b1; cmd.kind = K_CLIENT; state_nxt = S_ASCAN;
            end
            MODE_BIND:   state_nxt = S_RANGE;
            MODE_EXPIRE: begin
              cmd.start = 1'b1; cmd.kind = K_AEXP; state_nxt = S_SWA;
            end
            default:     state_nxt = S_REPLY;
          endcase
        end
      end
      S_RANGE: begin
        if (sts.range_bad) begin
          cmd.set_st = 1'b1; cmd.st = STAT_RANGE; state_nxt = S_REPLY;
        end else begin
          cmd.start = 1'b1; cmd.kind = K_ID; state_nxt = S_ASCAN;
        end
      end
      S_ASCAN: begin
        cmd.run = 1'b1;
        if (sts.done) begin
          state_nxt = S_REPLY;
          if (mode_r == MODE_ALLOC) begin
            if (sts.free) begin
              cmd.alloc = 1'b1; state_nxt = S_CLRP0;
            end else begin
              cmd.set_st = 1'b1; cmd.st = STAT_FULL;
            end
          end else if (!sts.hit) begin
            cmd.set_st = 1'b1; cmd.st = STAT_NOTFOUND;
          end else begin
            cmd.sel = 1'b1;
            case (mode_r)
              MODE_DEALLOC: cmd.drop = 1'b1;
              MODE_REFRESH: begin
                if (sts.life_zero) cmd.drop = 1'b1;
                else cmd.refresh = 1'b1;
              end
              MODE_PERMIT, MODE_CHECK, MODE_BIND, MODE_FINDCH: state_nxt = S_RSTART;
              default: ;
            endcase
          end
        end
      end
      S_RSTART: begin
        cmd.start = 1'b1;
        state_nxt = S_RSCAN;
        case (mode_r)
          MODE_PERMIT: cmd.kind = K_PERM;
          MODE_CHECK:  cmd.kind = K_PERML;
          MODE_BIND:   cmd.kind = K_CHAN;
          default:     cmd.kind = K_CHANL;
        endcase
      end
      S_RSCAN: begin
        cmd.run = 1'b1;
        if (sts.done) begin
          state_nxt = S_REPLY;
          case (mode_r)
            MODE_PERMIT: begin
              if (sts.hit || sts.free) cmd.perm_wr = 1'b1;
              else begin
                cmd.set_st = 1'b1; cmd.st = STAT_FULL;
              end
            end
            MODE_BIND: begin
              if (sts.hit && sts.conflict) begin
                cmd.set_st = 1'b1; cmd.st = STAT_CONFLICT;
              end else if (sts.hit || sts.free) begin
                cmd.chan_wr = 1'b1;
              end else begin
                cmd.set_st = 1'b1; cmd.st = STAT_FULL;
              end
            end
            MODE_FINDCH: begin
              if (sts.hit) cmd.peer = 1'b1;
              else begin
                cmd.set_st = 1'b1; cmd.st = STAT_NOTFOUND;
              end
            end
            default: begin
              if (!sts.hit) begin
                cmd.set_st = 1'b1; cmd.st = STAT_NOTFOUND;
              end
            end
          endcase
        end
      end
      S_CLRP0: begin
        cmd.start = 1'b1; cmd.kind = K_CLRP; state_nxt = S_CLRP;
      end
      S_CLRP: begin
        cmd.run = 1'b1;
        if (sts.done) begin
          cmd.run = 1'b0; cmd.start = 1'b1; cmd.kind = K_CLRC; state_nxt = S_CLRC;
        end
      end
      S_CLRC: begin
        cmd.run = 1'b1;
        if (sts.done) state_nxt = S_REPLY;
      end
      S_SWA: begin
        cmd.run = 1'b1;
        if (sts.done) begin
          cmd.run = 1'b0; cmd.start = 1'b1; cmd.kind = K_PEXP; state_nxt = S_SWP;
        end
      end
      S_SWP: begin
        cmd.run = 1'b1;
        if (sts.done) begin
          cmd.run = 1'b0; cmd.start = 1'b1; cmd.kind = K_CEXP; state_nxt = S_SWC;
        end
      end
      S_SWC: begin
        cmd.run = 1'b1;
        if (sts.done) state_nxt = S_REPLY;
      end
      S_REPLY: begin
        reply = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// File: rtl/core/rat_datapath.sv
// tables, scan engine, counters and result registers of the relay allocation table
module rat_datapath import rat_pkg::*; #(
  parameter int MAX_ALLOCS   = RAT_MAX_ALLOCS,
  parameter int MAX_PERMS    = RAT_MAX_PERMS,
  parameter int MAX_CHANNELS = RAT_MAX_CHANNELS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic [31:0] in_now_seconds,
  input  logic [31:0] in_client_address,
  input  logic [15:0] in_client_port_in,
  input  logic [31:0] in_allocation_id,
  input  logic [15:0] in_lifetime_seconds,
  input  logic [31:0] in_peer_address,
  input  logic [15:0] in_peer_port_in,
  input  logic [15:0] in_channel_number,
  input  cmd_t        cmd,
  output sts_t        sts,
  output logic [2:0]  res_status,
  output logic [31:0] res_id,
  output logic [15:0] res_port,
  output logic [31:0] res_paddr,
  output logic [15:0] res_pport,
  output logic [10:0] res_expired,
  output logic [6:0]  res_count
);

  localparam int AW   = (MAX_ALLOCS > 1) ? $clog2(MAX_ALLOCS) : 1;
  localparam int CMAX = (MAX_PERMS > MAX_CHANNELS) ? MAX_PERMS : MAX_CHANNELS;
  localparam int CW   = (CMAX > 1) ? $clog2(CMAX) : 1;
  localparam int PD   = MAX_ALLOCS * MAX_PERMS;
  localparam int CD   = MAX_ALLOCS * MAX_CHANNELS;
  localparam int PAW  = (PD > 1) ? $clog2(PD) : 1;
  localparam int CAW  = (CD > 1) ? $clog2(CD) : 1;
  localparam int LW   = $clog2(MAX_ALLOCS + 1);

  // configuration
  logic [15:0] deflt_r, maxl_r, chlo_r, chhi_r, pbase_r, plife_r, clife_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deflt_r <= RST_DEFAULT_LIFE;
      maxl_r  <= RST_MAX_LIFE;
      chlo_r  <= RST_CHAN_LOW;
      chhi_r  <= RST_CHAN_HIGH;
      pbase_r <= RST_PORT_BASE;
      plife_r <= RST_PERM_LIFE;
      clife_r <= RST_CHAN_LIFE;
    end else if (cfg_wr) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_RELAY_ADDR:   ; // relay address is never reported
        CFG_DEFAULT_LIFE: deflt_r <= cfg_data[15:0];
        CFG_MAX_LIFE:     maxl_r  <= cfg_data[15:0];
        CFG_CHAN_LOW:     chlo_r  <= cfg_data[15:0];
        CFG_CHAN_HIGH:    chhi_r  <= cfg_data[15:0];
        CFG_PORT_BASE:    pbase_r <= cfg_data[15:0];
        CFG_PERM_LIFE:    plife_r <= cfg_data[15:0];
        CFG_CHAN_LIFE:    clife_r <= cfg_data[15:0];
      endcase
    end
  end

  // latched request
  logic [31:0] now_r, caddr_r, id_r, paddr_r;
  logic [15:0] cport_r, life_r, pport_r, chn_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      now_r   <= in_now_seconds;
      caddr_r <= in_client_address;
      cport_r <= in_client_port_in;
      id_r    <= in_allocation_id;
      life_r  <= in_lifetime_seconds;
      paddr_r <= in_peer_address;
      pport_r <= in_peer_port_in;
      chn_r   <= in_channel_number;
    end
  end

  // scan engine
  scan_kind_t     kind_r;
  logic [AW-1:0]  ir_r, rlast_r, cr_r, sel_r, hit_row_r, free_row_r;
  logic [CW-1:0]  ic_r, clast_r, cc_r, hit_col_r, free_col_r;
  logic           issued_r, pend_r, hit_r, free_r;
  logic [31:0]    cap_id_r, cap_paddr_r;
  logic [15:0]    cap_port_r, cap_pport_r;

  logic row_kind, perm_kind, chan_kind;
  always_comb begin
    row_kind  = (cmd.kind == K_PERM) || (cmd.kind == K_PERML) || (cmd.kind == K_CHAN) ||
                (cmd.kind == K_CHANL) || (cmd.kind == K_CLRP) || (cmd.kind == K_CLRC);
    perm_kind = (cmd.kind == K_PERM) || (cmd.kind == K_PERML) || (cmd.kind == K_PEXP) ||
                (cmd.kind == K_CLRP);
    chan_kind = (cmd.kind == K_CHAN) || (cmd.kind == K_CHANL) || (cmd.kind == K_CEXP) ||
                (cmd.kind == K_CLRC);
  end

  // memories
  ainfo_t    info_mem [MAX_ALLOCS];
  logic [32:0] aexp_mem [MAX_ALLOCS];
  perm_ent_t perm_mem [PD];
  chan_ent_t chan_mem [CD];
  ainfo_t    info_rd;
  logic [32:0] aexp_rd;
  perm_ent_t perm_rd;
  chan_ent_t chan_rd;

  logic [MAX_ALLOCS-1:0] avalid_r;
  logic [LW-1:0]         live_r;
  logic [31:0]           nid_r;
  logic [15:0]           rport_r;
  logic [10:0]           exp_cnt_r;

  logic [PAW-1:0] p_ra, p_wa;
  logic [CAW-1:0] c_ra, c_wa;
  logic           p_we, c_we;
  perm_ent_t      p_wd;
  chan_ent_t      c_wd;
  logic [CW-1:0]  wcol;

  assign p_ra = PAW'(int'(ir_r) * MAX_PERMS + int'(ic_r));
  assign c_ra = CAW'(int'(ir_r) * MAX_CHANNELS + int'(ic_r));

  // compare stage
  logic [32:0] now33;
  logic        av, p_live, c_live, match, free_m, hit_now, free_now;
  logic [15:0] l0, life_eff;

  assign now33 = {1'b0, now_r};
  assign av     = avalid_r[cr_r];
  assign p_live = perm_rd.expiry > now33;
  assign c_live = chan_rd.expiry > now33;

  always_comb begin
    unique case (kind_r)
      K_FREE:   match = 1'b0;
      K_ID:     match = av && (info_rd.ident == id_r);
      K_CLIENT: match = av && (info_rd.caddr == caddr_r) && (info_rd.cport == cport_r);
      K_AEXP:   match = av && (aexp_rd <= now33);
      K_PERM:   match = perm_rd.valid && (perm_rd.peer == paddr_r);
      K_PERML:  match = perm_rd.valid && (perm_rd.peer == paddr_r) && p_live;
      K_CHAN:   match = chan_rd.valid && (chan_rd.number == chn_r);
      K_CHANL:  match = chan_rd.valid && (chan_rd.number == chn_r) && c_live;
      K_PEXP:   match = av && perm_rd.valid && !p_live;
      K_CEXP:   match = av && chan_rd.valid && !c_live;
      K_CLRP:   match = 1'b1;
      K_CLRC:   match = 1'b1;
      default:  match = 1'b0;
    endcase
    unique case (kind_r)
      K_FREE, K_ID, K_CLIENT, K_AEXP: free_m = !av;
      K_PERM, K_PERML:                free_m = !perm_rd.valid;
      K_CHAN, K_CHANL:                free_m = !chan_rd.valid;
      default:                        free_m = 1'b0;
    endcase
  end

  assign hit_now  = pend_r && match;
  assign free_now = pend_r && free_m;

  // lifetime: zero takes the default, then clamp
  assign l0       = (life_r == 16'd0) ? deflt_r : life_r;
  assign life_eff = (l0 > maxl_r) ? maxl_r : l0;

  assign wcol = hit_r ? hit_col_r : free_col_r;

  always_comb begin
    p_we = cmd.perm_wr || (hit_now && ((kind_r == K_PEXP) || (kind_r == K_CLRP)));
    p_wa = PAW'(int'(cr_r) * MAX_PERMS + int'(cc_r));
    p_wd = '0;
    if (cmd.perm_wr) begin
      p_wa = PAW'(int'(sel_r) * MAX_PERMS + int'(wcol));
      p_wd = '{valid: 1'b1, peer: paddr_r, expiry: now33 + 33'(plife_r)};
    end
    c_we = cmd.chan_wr || (hit_now && ((kind_r == K_CEXP) || (kind_r == K_CLRC)));
    c_wa = CAW'(int'(cr_r) * MAX_CHANNELS + int'(cc_r));
    c_wd = '0;
    if (cmd.chan_wr) begin
      c_wa = CAW'(int'(sel_r) * MAX_CHANNELS + int'(wcol));
      c_wd = '{valid: 1'b1, number: chn_r, paddr: paddr_r, pport: pport_r,
               expiry: now33 + 33'(clife_r)};
    end
  end

  always_ff @(posedge clk) begin
    info_rd <= info_mem[ir_r];
    aexp_rd <= aexp_mem[ir_r];
    perm_rd <= perm_mem[p_ra];
    chan_rd <= chan_mem[c_ra];
    if (cmd.alloc) begin
      info_mem[free_row_r] <= '{ident: nid_r, caddr: caddr_r, cport: cport_r, rport: rport_r};
      aexp_mem[free_row_r] <= now33 + 33'(life_eff);
    end
    if (cmd.refresh) aexp_mem[hit_row_r] <= now33 + 33'(life_eff);
    if (p_we) perm_mem[p_wa] <= p_wd;
    if (c_we) chan_mem[c_wa] <= c_wd;
  end

  // scan control and first-hit capture
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      issued_r <= 1'b1;
      pend_r   <= 1'b0;
      hit_r    <= 1'b0;
      free_r   <= 1'b0;
      kind_r   <= K_FREE;
    end else if (cmd.start) begin
      kind_r   <= cmd.kind;
      ir_r     <= row_kind ? sel_r : '0;
      rlast_r  <= row_kind ? sel_r : AW'(MAX_ALLOCS - 1);
      ic_r     <= '0;
      clast_r  <= perm_kind ? CW'(MAX_PERMS - 1) : (chan_kind ? CW'(MAX_CHANNELS - 1) : '0);
      issued_r <= 1'b0;
      pend_r   <= 1'b0;
      hit_r    <= 1'b0;
      free_r   <= 1'b0;
    end else begin
      pend_r <= cmd.run && !issued_r;
      if (cmd.run && !issued_r) begin
        cr_r <= ir_r;
        cc_r <= ic_r;
        if (ic_r == clast_r) begin
          ic_r <= '0;
          if (ir_r == rlast_r) issued_r <= 1'b1;
          else ir_r <= ir_r + 1'b1;
        end else begin
          ic_r <= ic_r + 1'b1;
        end
      end
      if (hit_now && !hit_r) begin
        hit_r       <= 1'b1;
        hit_row_r   <= cr_r;
        hit_col_r   <= cc_r;
        cap_id_r    <= info_rd.ident;
        cap_port_r  <= info_rd.rport;
        cap_paddr_r <= chan_rd.paddr;
        cap_pport_r <= chan_rd.pport;
      end
      if (free_now && !free_r) begin
        free_r     <= 1'b1;
        free_row_r <= cr_r;
        free_col_r <= cc_r;
      end
    end
  end

  // allocation state and counters
  logic [15:0] rport_inc;
  assign rport_inc = rport_r + 16'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      avalid_r <= '0;
      live_r   <= '0;
      nid_r    <= RST_NEXT_IDENT;
      rport_r  <= RST_PORT_BASE;
    end else begin
      if (cmd.alloc) begin
        avalid_r[free_row_r] <= 1'b1;
        live_r  <= live_r + 1'b1;
        nid_r   <= nid_r + 32'd1;
        rport_r <= (rport_inc == 16'd0) ? pbase_r : rport_inc;
      end
      if (cmd.drop) begin
        avalid_r[hit_row_r] <= 1'b0;
        live_r <= live_r - 1'b1;
      end
      if (hit_now && (kind_r == K_AEXP)) begin
        avalid_r[cr_r] <= 1'b0;
        live_r <= live_r - 1'b1;
      end
    end
  end

  // result registers
  logic [2:0]  st_r;
  logic [31:0] rid_r, rpa_r;
  logic [15:0] rpt_r, rpp_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      st_r      <= STAT_OK;
      rid_r     <= '0;
      rpt_r     <= '0;
      rpa_r     <= '0;
      rpp_r     <= '0;
      exp_cnt_r <= '0;
    end else begin
      if (cmd.set_st) st_r <= cmd.st;
      if (cmd.sel) begin
        sel_r <= hit_row_r;
        rid_r <= cap_id_r;
        rpt_r <= cap_port_r;
      end
      if (cmd.alloc) begin
        sel_r <= free_row_r;
        rid_r <= nid_r;
        rpt_r <= rport_r;
      end
      if (cmd.peer) begin
        rpa_r <= cap_paddr_r;
        rpp_r <= cap_pport_r;
      end
      if (hit_now && ((kind_r == K_AEXP) || (kind_r == K_PEXP) || (kind_r == K_CEXP)))
        exp_cnt_r <= exp_cnt_r + 11'd1;
    end
  end

  assign sts.done      = issued_r && !pend_r;
  assign sts.hit       = hit_r;
  assign sts.free      = free_r;
  assign sts.conflict  = (cap_paddr_r != paddr_r) || (cap_pport_r != pport_r);
  assign sts.range_bad = (chn_r < chlo_r) || (chn_r > chhi_r);
  assign sts.life_zero = (life_r == 16'd0);

  assign res_status  = st_r;
  assign res_id      = rid_r;
  assign res_port    = rpt_r;
  assign res_paddr   = rpa_r;
  assign res_pport   = rpp_r;
  assign res_expired = exp_cnt_r;
  assign res_count   = 7'(live_r);

endmodule

// File: verif/tb.sv
// self-checking testbench for relay_allocation_table: directed and random requests
`timescale 1ns / 1ps

module tb;
  import rat_pkg::*;

  localparam int NA = RAT_MAX_ALLOCS;
  localparam int NP = RAT_MAX_PERMS;
  localparam int NC = RAT_MAX_CHANNELS;
  localparam int CYCLE_LIMIT = 3000000;
  // a full expire sweep is the slowest request
  localparam int SETTLE_CYCLES = 1300;

  typedef struct {
    logic [3:0]  mode;
    logic [31:0] now;
    logic [31:0] caddr;
    logic [15:0] cport;
    logic [31:0] id;
    logic [15:0] life;
    logic [31:0] paddr;
    logic [15:0] pport;
    logic [15:0] chn;
  } req_t;

  typedef struct {
    logic [2:0]  status;
    logic [31:0] fid;
    logic [15:0] fport;
    logic [31:0] fpaddr;
    logic [15:0] fpport;
    logic [10:0] expired;
    logic [6:0]  count;
  } reply_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [3:0]  in_mode;
  logic [31:0] in_now_seconds;
  logic [31:0] in_client_address;
  logic [15:0] in_client_port_in;
  logic [31:0] in_allocation_id;
  logic [15:0] in_lifetime_seconds;
  logic [31:0] in_peer_address;
  logic [15:0] in_peer_port_in;
  logic [15:0] in_channel_number;
  logic        out_valid;
  logic [2:0]  out_status;
  logic [31:0] out_found_id;
  logic [15:0] out_found_relay_port;
  logic [31:0] out_found_peer_address;
  logic [15:0] out_found_peer_port;
  logic [10:0] out_expired_count;
  logic [6:0]  out_allocation_count;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  relay_allocation_table dut (.*);

  // shadow copy of the table
  logic        a_val [NA];
  logic [31:0] a_id [NA];
  logic [31:0] a_caddr [NA];
  logic [15:0] a_cport [NA];
  logic [15:0] a_rport [NA];
  logic [32:0] a_exp [NA];
  logic        p_val [NA*NP];
  logic [31:0] p_peer [NA*NP];
  logic [32:0] p_exp [NA*NP];
  logic        c_val [NA*NC];
  logic [15:0] c_num [NA*NC];
  logic [31:0] c_paddr [NA*NC];
  logic [15:0] c_pport [NA*NC];
  logic [32:0] c_exp [NA*NC];
  logic [31:0] next_id;
  logic [15:0] shadow_port;
  logic [6:0]  live;

  // shadow copy of the registers
  logic [31:0] r_relay;
  logic [15:0] r_dflt, r_maxl, r_clo, r_chi, r_pbase, r_plife, r_clife;

  reply_t replies_due[$];
  int     errors;
  int     cycles;
  int     burst_left;
  logic [31:0] clock_s;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // runaway guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: %s got %0h want %0h", $realtime, what, got, want);
    errors++;
  endtask

  // every result beat lasts one cycle and is compared against the oldest prediction
  always @(posedge clk) begin
    reply_t e;
    if (rst_n && out_valid) begin
      if (replies_due.size() == 0) begin
        report_mismatch("unexpected result beat", 32'(out_status), 32'd0);
      end else begin
        e = replies_due.pop_front();
        if (out_status !== e.status)
          report_mismatch("status", 32'(out_status), 32'(e.status));
        if (out_found_id !== e.fid) report_mismatch("found_id", out_found_id, e.fid);
        if (out_found_relay_port !== e.fport)
          report_mismatch("found_relay_port", 32'(out_found_relay_port), 32'(e.fport));
        if (out_found_peer_address !== e.fpaddr)
          report_mismatch("found_peer_address", out_found_peer_address, e.fpaddr);
        if (out_found_peer_port !== e.fpport)
          report_mismatch("found_peer_port", 32'(out_found_peer_port), 32'(e.fpport));
        if (out_expired_count !== e.expired)
          report_mismatch("expired_count", 32'(out_expired_count), 32'(e.expired));
        if (out_allocation_count !== e.count)
          report_mismatch("allocation_count", 32'(out_allocation_count), 32'(e.count));
      end
    end
  end

  function automatic int lookup_slot(input logic [31:0] id);
    for (int i = 0; i < NA; i++)
      if (a_val[i] && a_id[i] == id) return i;
    return -1;
  endfunction

  function automatic void drop_slot(input int a);
    a_val[a] = 0;
    for (int j = 0; j < NP; j++) p_val[a*NP+j] = 0;
    for (int j = 0; j < NC; j++) c_val[a*NC+j] = 0;
    live--;
  endfunction

  // works out the reply of one request and updates the shadow table
  function automatic reply_t table_predict(input req_t r);
    reply_t e;
    int a, k, b;
    logic [15:0] life;
    logic [32:0] now33;
    e = '{default: '0};
    a = -1;
    life = r.life;
    now33 = {1'b0, r.now};
    case (r.mode)
      MODE_ALLOC: begin
        if (life == 0) life = r_dflt;
        if (life > r_maxl) life = r_maxl;
        for (int i = 0; i < NA && a < 0; i++)
          if (!a_val[i]) a = i;
        if (a < 0) begin
          e.status = STAT_FULL;
        end else begin
          a_val[a] = 1;
          a_id[a] = next_id;
          next_id++;
          a_caddr[a] = r.caddr;
          a_cport[a] = r.cport;
          a_rport[a] = shadow_port;
          a_exp[a] = now33 + life;
          shadow_port++;
          if (shadow_port == 0) shadow_port = r_pbase;
          live++;
        end
      end
      MODE_REFRESH, MODE_DEALLOC: begin
        a = lookup_slot(r.id);
        if (a < 0) begin
          e.status = STAT_NOTFOUND;
        end else if (r.mode == MODE_DEALLOC || life == 0) begin
          e.fid = a_id[a];
          e.fport = a_rport[a];
          drop_slot(a);
          a = -1;
        end else begin
          if (life > r_maxl) life = r_maxl;
          a_exp[a] = now33 + life;
        end
      end
      MODE_FIND: begin
        for (int i = 0; i < NA && a < 0; i++)
          if (a_val[i] && a_caddr[i] == r.caddr && a_cport[i] == r.cport) a = i;
        if (a < 0) e.status = STAT_NOTFOUND;
      end
      MODE_PERMIT: begin
        a = lookup_slot(r.id);
        if (a < 0) begin
          e.status = STAT_NOTFOUND;
        end else begin
          k = -1;
          for (int j = 0; j < NP && k < 0; j++)
            if (p_val[a*NP+j] && p_peer[a*NP+j] == r.paddr) k = j;
          for (int j = 0; j < NP && k < 0; j++)
            if (!p_val[a*NP+j]) k = j;
          if (k < 0) begin
            e.status = STAT_FULL;
          end else begin
            p_val[a*NP+k] = 1;
            p_peer[a*NP+k] = r.paddr;
            p_exp[a*NP+k] = now33 + r_plife;
          end
        end
      end
      MODE_CHECK: begin
        a = lookup_slot(r.id);
        e.status = STAT_NOTFOUND;
        if (a >= 0)
          for (int j = 0; j < NP; j++)
            if (p_val[a*NP+j] && p_peer[a*NP+j] == r.paddr && p_exp[a*NP+j] > now33)
              e.status = STAT_OK;
      end
      MODE_BIND: begin
        if (r.chn < r_clo || r.chn > r_chi) begin
          e.status = STAT_RANGE;
        end else begin
          a = lookup_slot(r.id);
          if (a < 0) begin
            e.status = STAT_NOTFOUND;
          end else begin
            k = -1;
            for (int j = 0; j < NC && k < 0; j++)
              if (c_val[a*NC+j] && c_num[a*NC+j] == r.chn) k = j;
            if (k >= 0) begin
              if (c_paddr[a*NC+k] != r.paddr || c_pport[a*NC+k] != r.pport)
                e.status = STAT_CONFLICT;
            end else begin
              for (int j = 0; j < NC && k < 0; j++)
                if (!c_val[a*NC+j]) k = j;
              if (k < 0) e.status = STAT_FULL;
            end
            if (e.status == STAT_OK) begin
              b = a*NC + k;
              c_val[b] = 1;
              c_num[b] = r.chn;
              c_paddr[b] = r.paddr;
              c_pport[b] = r.pport;
              c_exp[b] = now33 + r_clife;
            end
          end
        end
      end
      MODE_FINDCH: begin
        a = lookup_slot(r.id);
        e.status = STAT_NOTFOUND;
        if (a >= 0)
          for (int j = NC - 1; j >= 0; j--) begin
            // walk downward so the lowest matching slot is the one kept
            b = a*NC + j;
            if (c_val[b] && c_num[b] == r.chn && c_exp[b] > now33) begin
              e.status = STAT_OK;
              e.fpaddr = c_paddr[b];
              e.fpport = c_pport[b];
            end
          end
      end
      MODE_EXPIRE: begin
        for (int i = 0; i < NA; i++) begin
          if (!a_val[i]) continue;
          if (a_exp[i] <= now33) begin
            drop_slot(i);
            e.expired++;
            continue;
          end
          for (int j = 0; j < NP; j++)
            if (p_val[i*NP+j] && p_exp[i*NP+j] <= now33) begin
              p_val[i*NP+j] = 0;
              e.expired++;
            end
          for (int j = 0; j < NC; j++)
            if (c_val[i*NC+j] && c_exp[i*NC+j] <= now33) begin
              c_val[i*NC+j] = 0;
              e.expired++;
            end
        end
      end
      default: ;  // count and the unused codes change nothing
    endcase
    if (a >= 0) begin
      e.fid = a_id[a];
      e.fport = a_rport[a];
    end
    e.count = live;
    return e;
  endfunction

  // one request beat; start stays high into the next call unless a gap is due
  task automatic send_req(input req_t r);
    in_mode <= r.mode;
    in_now_seconds <= r.now;
    in_client_address <= r.caddr;
    in_client_port_in <= r.cport;
    in_allocation_id <= r.id;
    in_lifetime_seconds <= r.life;
    in_peer_address <= r.paddr;
    in_peer_port_in <= r.pport;
    in_channel_number <= r.chn;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    replies_due.push_back(table_predict(r));
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(0, 3) == 0 ? $urandom_range(20, 150) : $urandom_range(1, 6))
        @(posedge clk);
      burst_left = $urandom_range(0, 4) == 0 ? $urandom_range(15, 40) : $urandom_range(0, 6);
    end else begin
      burst_left--;
    end
  endtask

  task automatic drain;
    start <= 1'b0;
    @(posedge clk);
    while (replies_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [31:0] d);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_RELAY_ADDR:   r_relay = d;
      CFG_DEFAULT_LIFE: r_dflt = d[15:0];
      CFG_MAX_LIFE:     r_maxl = d[15:0];
      CFG_CHAN_LOW:     r_clo = d[15:0];
      CFG_CHAN_HIGH:    r_chi = d[15:0];
      CFG_PORT_BASE:    r_pbase = d[15:0];
      CFG_PERM_LIFE:    r_plife = d[15:0];
      default:          r_clife = d[15:0];
    endcase
  endtask

  function automatic req_t blank_req(input mode_t m, input logic [31:0] t);
    req_t r;
    r = '{default: '0};
    r.mode = m;
    r.now = t;
    return r;
  endfunction

  // basic allocation life cycle, lifetime defaulting and clamping, unused codes
  task automatic test_alloc_basics;
    req_t r;
    logic [31:0] id0;
    send_req(blank_req(MODE_COUNT, 0));
    id0 = next_id;
    r = blank_req(MODE_ALLOC, 100);            // zero lifetime takes the default
    r.caddr = 32'h0a000001; r.cport = 16'd5000;
    send_req(r);
    r = blank_req(MODE_ALLOC, 100);            // above the clamp
    r.caddr = 32'hffffffff; r.cport = 16'hffff; r.life = 16'hffff;
    send_req(r);
    r = blank_req(MODE_ALLOC, 32'hffffffff);  // expiry needs the 33rd bit
    r.caddr = 32'h0a000002; r.life = 16'd100;
    send_req(r);
    r = blank_req(MODE_FIND, 0);
    r.caddr = 32'hffffffff; r.cport = 16'hffff;
    send_req(r);
    r.cport = 16'hfffe;                        // no such client
    send_req(r);
    r = blank_req(MODE_REFRESH, 200);
    r.id = 32'hffffffff; r.life = 16'd10;      // unknown id
    send_req(r);
    r.id = id0; r.life = 16'hffff;             // renew, clamped
    send_req(r);
    r.life = 0;                                // zero lifetime deletes
    send_req(r);
    r = blank_req(MODE_DEALLOC, 200);
    r.id = id0;                                // already gone
    send_req(r);
    r.id = id0 + 1;
    send_req(r);
    send_req(blank_req(mode_t'(4'd10), 32'h55555555));
    send_req(blank_req(mode_t'(4'd15), 32'haaaaaaaa));
    r = blank_req(MODE_EXPIRE, 32'hfffffffe);  // the late allocation survives this
    send_req(r);
    r.now = 32'hffffffff;
    send_req(r);
  endtask

  // permission slots: create, refresh, fill, overflow, check hit and miss
  task automatic test_permissions;
    req_t r;
    logic [31:0] id0;
    id0 = next_id;
    send_req(blank_req(MODE_ALLOC, 1000));
    r = blank_req(MODE_PERMIT, 1000);
    r.id = id0;
    for (int j = 0; j <= NP; j++) begin
      r.paddr = 32'hc0a80000 + j;
      send_req(r);                             // the last one finds every slot taken
    end
    r.paddr = 32'hc0a80000; r.now = 1100;      // refresh of an existing peer
    send_req(r);
    r.id = 32'h0;
    send_req(r);                               // unknown id
    r = blank_req(MODE_CHECK, 1200);
    r.id = id0; r.paddr = 32'hc0a80001;
    send_req(r);
    r.now = 1300;                              // right at expiry: no longer valid
    send_req(r);
    r.paddr = 32'hc0a80000;                    // refreshed one still holds
    send_req(r);
    r.paddr = 32'hdeadbeef;
    send_req(r);
    r.id = 32'hfffffff0;
    send_req(r);
  endtask

  // channel range, unknown id, bind, rebind, conflict, fill and lookups
  task automatic test_channels;
    req_t r;
    logic [31:0] id0;
    id0 = next_id;
    send_req(blank_req(MODE_ALLOC, 2000));
    r = blank_req(MODE_BIND, 2000);
    r.id = id0; r.paddr = 32'h08080808; r.pport = 16'hffff;
    r.chn = r_clo - 16'd1;
    send_req(r);
    r.chn = r_chi + 16'd1;
    send_req(r);
    r.chn = r_clo; r.id = 32'h12345678;        // in range but unknown id
    send_req(r);
    r.id = id0;
    send_req(r);
    send_req(r);                               // same peer rebinds
    r.pport = 16'd1;                           // different peer
    send_req(r);
    for (int j = 1; j <= NC; j++) begin
      r.chn = r_chi - 16'(j) + 16'd1;
      send_req(r);                             // the last one overflows the row
    end
    r = blank_req(MODE_FINDCH, 2100);
    r.id = id0; r.chn = r_clo;
    send_req(r);
    r.chn = 16'd1;
    send_req(r);
    r.id = 32'hffffffff;
    send_req(r);
    r = blank_req(MODE_FINDCH, 2000 + r_clife);  // expired binding is not found
    r.id = id0; r.chn = r_clo;
    send_req(r);
  endtask

  // fill the allocation table, overflow it, then sweep out every expired allocation
  task automatic test_table_full;
    req_t r;
    r = blank_req(MODE_ALLOC, 3000);
    r.life = 16'd50;
    while (live < NA) begin
      r.caddr = $urandom();
      send_req(r);
    end
    send_req(r);
    send_req(blank_req(MODE_COUNT, 0));
    // hold off until everything is back before sweeping
    drain();
    send_req(blank_req(MODE_EXPIRE, 32'hffffffff));
  endtask

  function automatic logic [31:0] pick_addr(input logic [31:0] base);
    if ($urandom_range(0, 9) == 0) return $urandom();
    return base + $urandom_range(0, 5);
  endfunction

  function automatic logic [15:0] pick_port();
    if ($urandom_range(0, 9) == 0) return 16'($urandom());
    return 16'd3478 + 16'($urandom_range(0, 3));
  endfunction

  function automatic logic [31:0] pick_id();
    int s;
    if (live != 0 && $urandom_range(0, 9) < 8) begin
      s = $urandom_range(0, NA - 1);
      while (!a_val[s]) s = (s + 1) % NA;
      return a_id[s];
    end
    return $urandom_range(0, 1) ? $urandom() : next_id;
  endfunction

  function automatic logic [15:0] pick_chan();
    case ($urandom_range(0, 9))
      0: return 16'($urandom());
      1: return r_clo - 16'd1;
      2: return r_chi + 16'd1;
      3: return r_chi;
      default: return r_clo + 16'($urandom_range(0, 9));
    endcase
  endfunction

  // mostly well-formed traffic against live allocations, some noise
  task automatic test_random(input int n);
    req_t r;
    int w;
    for (int t = 0; t < n; t++) begin
      clock_s = clock_s + $urandom_range(0, 25);
      if ($urandom_range(0, 49) == 0) clock_s = $urandom();
      w = $urandom_range(0, 99);
      r = blank_req(MODE_COUNT, clock_s);
      if      (w < 20) r.mode = MODE_ALLOC;
      else if (w < 28) r.mode = MODE_REFRESH;
      else if (w < 33) r.mode = MODE_DEALLOC;
      else if (w < 40) r.mode = MODE_FIND;
      else if (w < 54) r.mode = MODE_PERMIT;
      else if (w < 66) r.mode = MODE_CHECK;
      else if (w < 80) r.mode = MODE_BIND;
      else if (w < 91) r.mode = MODE_FINDCH;
      else if (w < 95) r.mode = MODE_EXPIRE;
      else if (w < 97) r.mode = MODE_COUNT;
      else r.mode = 4'($urandom_range(10, 15));
      r.caddr = pick_addr(32'h0a000000);
      r.cport = pick_port();
      r.id = pick_id();
      case ($urandom_range(0, 19))
        0, 1:    r.life = 0;
        2:       r.life = 16'hffff;
        3:       r.life = 16'($urandom());
        default: r.life = 16'($urandom_range(1, 120));
      endcase
      r.paddr = pick_addr(32'hc6336400);
      r.pport = pick_port();
      r.chn = pick_chan();
      send_req(r);
    end
  endtask

  initial begin
    errors = 0;
    cycles = 0;
    burst_left = 0;
    clock_s = 0;
    rst_n = 1'b0;
    start = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_RELAY_ADDR;
    cfg_data = '0;
    in_mode = MODE_COUNT;
    in_now_seconds = '0;
    in_client_address = '0;
    in_client_port_in = '0;
    in_allocation_id = '0;
    in_lifetime_seconds = '0;
    in_peer_address = '0;
    in_peer_port_in = '0;
    in_channel_number = '0;
    for (int i = 0; i < NA; i++) a_val[i] = 0;
    for (int i = 0; i < NA*NP; i++) p_val[i] = 0;
    for (int i = 0; i < NA*NC; i++) c_val[i] = 0;
    next_id = RST_NEXT_IDENT;
    shadow_port = RST_PORT_BASE;
    live = 0;
    r_relay = '0;
    r_dflt = RST_DEFAULT_LIFE;
    r_maxl = RST_MAX_LIFE;
    r_clo = RST_CHAN_LOW;
    r_chi = RST_CHAN_HIGH;
    r_pbase = RST_PORT_BASE;
    r_plife = RST_PERM_LIFE;
    r_clife = RST_CHAN_LIFE;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_alloc_basics();
    test_permissions();
    test_channels();
    test_table_full();
    test_random(160);

    // short lifetimes so entries age out between requests
    write_reg(CFG_RELAY_ADDR, 32'hcb007101);
    write_reg(CFG_DEFAULT_LIFE, 32'd1);
    write_reg(CFG_MAX_LIFE, 32'd40);
    write_reg(CFG_PERM_LIFE, 32'd1);
    write_reg(CFG_CHAN_LIFE, 32'd30);
    write_reg(CFG_CHAN_LOW, 32'd100);
    write_reg(CFG_CHAN_HIGH, 32'd104);
    write_reg(CFG_PORT_BASE, 32'd0);
    test_random(140);

    // widest settings
    write_reg(CFG_RELAY_ADDR, 32'hffffffff);
    write_reg(CFG_DEFAULT_LIFE, 32'hffff);
    write_reg(CFG_MAX_LIFE, 32'hffff);
    write_reg(CFG_PERM_LIFE, 32'hffff);
    write_reg(CFG_CHAN_LIFE, 32'hffff);
    write_reg(CFG_CHAN_LOW, 32'd0);
    write_reg(CFG_CHAN_HIGH, 32'hffff);
    write_reg(CFG_PORT_BASE, 32'hffff);
    test_random(90);

    // inverted channel range rejects every bind
    write_reg(CFG_CHAN_LOW, 32'd5000);
    write_reg(CFG_CHAN_HIGH, 32'd4999);
    write_reg(CFG_RELAY_ADDR, 32'd0);
    test_random(40);

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/rat_pkg.sv
rtl/core/rat_ctrl.sv
rtl/core/rat_datapath.sv
rtl/core/relay_allocation_table.sv
verif/tb.sv
